[hw/rtl/fut_pkg.sv]
package fut_pkg;

  // Letters tracked; symbols at or above this are ignored
  localparam int unsigned ALPHABET = 26;
  localparam int unsigned SYM_W    = 5;
  localparam int unsigned TDATA_W  = 8;

  typedef logic [SYM_W-1:0] sym_t;

  // Saturating occurrence count per letter
  typedef enum logic [1:0] {
    CNT_ZERO = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } cnt_e;

  // Update to the order list caused by one transaction
  typedef struct packed {
    logic nx_we;
    sym_t nx_addr;
    sym_t nx_data;
    logic pv_we;
    sym_t pv_addr;
    sym_t pv_data;
  } link_wr_t;

endpackage

[hw/rtl/first_unique_symbol_tracker.sv]
// An input transaction passes the input register, then the result register.
// Throughput: one symbol per cycle unless a waiting result stalls the input;
//   counts, list head and tail and the link tables are updated in the same cycle
//   the symbol leaves the input register.
// Reset: counts, list head, tail and nonempty flag, and both stage valids clear at once.
//   Link tables are not reset; an entry is always written before it is read.
module first_unique_symbol_tracker import fut_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,   // [4:0] symbol, [7:5] zero
  input  logic               s_axis_tuser_i,   // [0] new_stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // [4:0] first_symbol, [7:5] zero
  output logic               m_axis_tuser_o    // [0] found
);

  // Input register
  logic in_vld_q;
  sym_t in_sym_q;
  logic in_new_q;

  // Result register
  logic out_vld_q;
  sym_t out_sym_q, out_sym_d;
  logic out_found_q, out_found_d;

  // Tracker state
  cnt_e cnt_q [ALPHABET];
  cnt_e cnt_d [ALPHABET];
  sym_t head_q, head_d;
  sym_t tail_q, tail_d;
  logic ne_q, ne_d;
  sym_t next_q [ALPHABET];
  sym_t prev_q [ALPHABET];

  logic     advance;
  logic     in_range;
  cnt_e     cnt_cur;
  sym_t     head_cur, tail_cur;
  logic     ne_cur;
  sym_t     nx_of_s, pv_of_s;
  link_wr_t lw;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_sym_q <= s_axis_tdata_i[SYM_W-1:0];
      in_new_q <= s_axis_tuser_i;
    end
  end

  assign in_range = ({1'b0, in_sym_q} < (SYM_W+1)'(ALPHABET));
  assign nx_of_s  = next_q[in_sym_q];
  assign pv_of_s  = prev_q[in_sym_q];

  // A new stream starts from an empty list and zero counts
  assign cnt_cur  = in_new_q ? CNT_ZERO : cnt_q[in_sym_q];
  assign ne_cur   = in_new_q ? 1'b0 : ne_q;
  assign head_cur = in_new_q ? '0 : head_q;
  assign tail_cur = in_new_q ? '0 : tail_q;

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      cnt_d[i] = in_new_q ? CNT_ZERO : cnt_q[i];
    end
    head_d = head_cur;
    tail_d = tail_cur;
    ne_d   = ne_cur;
    lw     = '0;
    if (in_range) begin
      case (cnt_cur)
        CNT_ZERO: begin
          // First occurrence: append at tail
          cnt_d[in_sym_q] = CNT_ONE;
          if (!ne_cur) begin
            head_d = in_sym_q;
            tail_d = in_sym_q;
            ne_d   = 1'b1;
          end else begin
            lw.nx_we   = 1'b1;
            lw.nx_addr = tail_cur;
            lw.nx_data = in_sym_q;
            lw.pv_we   = 1'b1;
            lw.pv_addr = in_sym_q;
            lw.pv_data = tail_cur;
            tail_d     = in_sym_q;
          end
        end
        CNT_ONE: begin
          // Second occurrence: unlink
          cnt_d[in_sym_q] = CNT_TWO;
          if (ne_cur) begin
            if (in_sym_q == head_cur) begin
              if (in_sym_q == tail_cur) ne_d = 1'b0;
              else                      head_d = nx_of_s;
            end else if (in_sym_q == tail_cur) begin
              tail_d = pv_of_s;
            end else begin
              lw.nx_we   = 1'b1;
              lw.nx_addr = pv_of_s;
              lw.nx_data = nx_of_s;
              lw.pv_we   = 1'b1;
              lw.pv_addr = nx_of_s;
              lw.pv_data = pv_of_s;
            end
          end
        end
        default: ;
      endcase
    end
    out_found_d = ne_d;
    out_sym_d   = ne_d ? head_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_q[i] <= CNT_ZERO;
      end
      head_q <= '0;
      tail_q <= '0;
      ne_q   <= 1'b0;
    end else if (advance) begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
      tail_q <= tail_d;
      ne_q   <= ne_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && lw.nx_we) begin
      next_q[lw.nx_addr] <= lw.nx_data;
    end
    if (advance && lw.pv_we) begin
      prev_q[lw.pv_addr] <= lw.pv_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sym_q   <= out_sym_d;
      out_found_q <= out_found_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TDATA_W'(out_sym_q);
  assign m_axis_tuser_o  = out_found_q;

  // Head and tail of a nonempty list are letters seen exactly once
  a_head_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ne_q |-> (cnt_q[head_q] == CNT_ONE))
    else $error("list head does not have count one");

  a_tail_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ne_q |-> (cnt_q[tail_q] == CNT_ONE))
    else $error("list tail does not have count one");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_found_q) |-> (out_sym_q == '0))
    else $error("first_symbol nonzero while nothing found");

  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed symbol produced no result");

  a_found_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_found_q == ne_q) && (!ne_q || (out_sym_q == head_q)))
    else $error("result does not match list head");

endmodule
